// ===== rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// shared types and constants of the point to segment distance unit
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int DIST_BITS    = 17;
   localparam int TOL_BITS     = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 17'h1FFFF;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SEG_START_X = 3'd0,
      CSR_SEG_START_Y = 3'd1,
      CSR_SEG_END_X   = 3'd2,
      CSR_SEG_END_Y   = 3'd3,
      CSR_TOL         = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      MUL_P1X_P1X = 4'd0,
      MUL_P1Y_P1Y = 4'd1,
      MUL_P2X_P2X = 4'd2,
      MUL_P2Y_P2Y = 4'd3,
      MUL_DX_DX   = 4'd4,
      MUL_DY_DY   = 4'd5,
      MUL_P1X_DX  = 4'd6,
      MUL_P1Y_DY  = 4'd7,
      MUL_P1X_DY  = 4'd8,
      MUL_P1Y_DX  = 4'd9,
      MUL_CHI_CHI = 4'd10,
      MUL_CHI_CLO = 4'd11,
      MUL_CLO_CLO = 4'd12
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE    = 3'd0,
      ACC_LOAD    = 3'd1,
      ACC_ADD     = 3'd2,
      ACC_SUB     = 3'd3,
      ACC_LOAD_HI = 3'd4,
      ACC_ADD_MID = 3'd5
   } acc_op_type;

   typedef enum logic [2:0] {
      ST_NONE = 3'd0,
      ST_P1SQ = 3'd1,
      ST_P2SQ = 3'd2,
      ST_LEN2 = 3'd3,
      ST_DOT  = 3'd4,
      ST_C    = 3'd5,
      ST_CSQ  = 3'd6
   } store_type;

   typedef enum logic [1:0] {
      SRC_P1SQ = 2'd0,
      SRC_MIN  = 2'd1,
      SRC_QUOT = 2'd2
   } sqrt_src_type;

   typedef struct packed {
      logic         capture;
      logic         mul_en;
      mul_sel_type  mul_sel;
      acc_op_type   acc_op;
      store_type    store;
      logic         div_load;
      logic         div_step;
      logic         sqrt_load;
      sqrt_src_type sqrt_src;
      logic         sqrt_step;
      logic         result_load;
   } cmd_type;

   typedef struct packed {
      logic collapsed;
      logic outside;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/psd_ifs.sv =====
// ----------------------------------------------------------------------------
// psd channel interfaces
// request, response and register write channels
// ----------------------------------------------------------------------------
interface psd_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         first_of_set;
   modport source (output valid, point_x, point_y, first_of_set, input ready);
   modport sink (input valid, point_x, point_y, first_of_set, output ready);
endinterface

interface psd_rsp_if ();
   logic        valid;
   logic        ready;
   logic [16:0] point_distance;
   logic [16:0] running_min;
   modport source (output valid, point_distance, running_min, input ready);
   modport sink (input valid, point_distance, running_min, output ready);
endinterface

interface psd_csr_if #(parameter int COORD_BITS = 16) ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            index;
   logic [COORD_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/psd_ctrl.sv =====
// ----------------------------------------------------------------------------
// psd_ctrl
// sequencer: product steps, divide and square root iterations, result hand-off
// ----------------------------------------------------------------------------
module psd_ctrl #(
   parameter int COORD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  psd_pkg::status_type  status,
   output psd_pkg::cmd_type     cmd
);
   import psd_pkg::*;

   localparam int CW  = (COORD_BITS < 30) ? COORD_BITS : 30;
   localparam int QW  = 2 * CW + 1;
   localparam int RW  = CW + 1;
   localparam int ITW = $clog2(QW + 1);
   localparam logic [3:0] OP_LAST = 4'd12;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_MUL    = 8'b00000010,
      S_ACC    = 8'b00000100,
      S_DECIDE = 8'b00001000,
      S_DIV    = 8'b00010000,
      S_SQLOAD = 8'b00100000,
      S_SQRT   = 8'b01000000,
      S_DONE   = 8'b10000000
   } state_type;

   state_type      state_ff, state_in;
   logic [3:0]     op_ff, op_in;
   logic [ITW-1:0] cnt_ff, cnt_in;
   acc_op_type     op_acc;
   store_type      op_store;

   always_comb begin
      case (op_ff)
         4'd0:    begin op_acc = ACC_LOAD;    op_store = ST_NONE; end
         4'd1:    begin op_acc = ACC_ADD;     op_store = ST_P1SQ; end
         4'd2:    begin op_acc = ACC_LOAD;    op_store = ST_NONE; end
         4'd3:    begin op_acc = ACC_ADD;     op_store = ST_P2SQ; end
         4'd4:    begin op_acc = ACC_LOAD;    op_store = ST_NONE; end
         4'd5:    begin op_acc = ACC_ADD;     op_store = ST_LEN2; end
         4'd6:    begin op_acc = ACC_LOAD;    op_store = ST_NONE; end
         4'd7:    begin op_acc = ACC_ADD;     op_store = ST_DOT;  end
         4'd8:    begin op_acc = ACC_LOAD;    op_store = ST_NONE; end
         4'd9:    begin op_acc = ACC_SUB;     op_store = ST_C;    end
         4'd10:   begin op_acc = ACC_LOAD_HI; op_store = ST_NONE; end
         4'd11:   begin op_acc = ACC_ADD_MID; op_store = ST_NONE; end
         4'd12:   begin op_acc = ACC_ADD;     op_store = ST_CSQ;  end
         default: begin op_acc = ACC_NONE;    op_store = ST_NONE; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = mul_sel_type'(op_ff);
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_op = op_acc;
            cmd.store  = op_store;
            if (op_ff == OP_LAST) begin
               state_in = S_DECIDE;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         S_DECIDE: begin
            cnt_in = '0;
            if (status.collapsed) begin
               cmd.sqrt_load = 1'b1;
               cmd.sqrt_src  = SRC_P1SQ;
               state_in      = S_SQRT;
            end else if (status.outside) begin
               cmd.sqrt_load = 1'b1;
               cmd.sqrt_src  = SRC_MIN;
               state_in      = S_SQRT;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == ITW'(QW - 1)) begin
               state_in = S_SQLOAD;
            end
         end
         S_SQLOAD: begin
            cmd.sqrt_load = 1'b1;
            cmd.sqrt_src  = SRC_QUOT;
            cnt_in        = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ITW'(RW - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/psd_datapath.sv =====
// ----------------------------------------------------------------------------
// psd_datapath
// segment registers, shared multiplier and accumulator, restoring divider,
// digit-by-digit square root, running minimum and response register
// ----------------------------------------------------------------------------
module psd_datapath #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psd_pkg::cmd_type              cmd,
   output psd_pkg::status_type           status,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic                          req_first_of_set,
   input  logic                          csr_valid,
   input  logic [2:0]                    csr_index,
   input  logic [COORD_BITS-1:0]         csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [psd_pkg::DIST_BITS-1:0] rsp_point_distance,
   output logic [psd_pkg::DIST_BITS-1:0] rsp_running_min
);
   import psd_pkg::*;

   localparam int CW  = (COORD_BITS < 30) ? COORD_BITS : 30;
   localparam int DW  = CW + 1;
   localparam int MW  = CW + 2;
   localparam int PW  = 2 * MW;
   localparam int AW  = 4 * CW + 4;
   localparam int SQW = 2 * CW + 3;
   localparam int CBW = 2 * CW + 2;
   localparam int CMW = 2 * CW + 1;
   localparam int K   = CW + 1;
   localparam int NW  = 4 * CW + 2;
   localparam int QW  = 2 * CW + 1;
   localparam int LW  = SQW + 1;
   localparam int SW  = 2 * CW + 2;
   localparam int RW  = CW + 1;
   localparam int XW  = (RW > DIST_BITS) ? RW : DIST_BITS;

   logic signed [CW-1:0]  sx_ff, sy_ff, ex_ff, ey_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   logic                  first_ff;
   logic signed [DW-1:0]  dx_ff, dy_ff, p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [DW-1:0]  px_ext, py_ext, sx_ext, sy_ext, ex_ext, ey_ext;
   logic [DW-1:0]         dx_mag, dy_mag;
   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]  prod_ff;
   logic signed [AW-1:0]  acc_ff, acc_in, prod_ext;
   logic [SQW-1:0]        p1sq_ff, p2sq_ff, len2_ff;
   logic signed [SQW-1:0] dot_ff;
   logic signed [CBW-1:0] c_ff;
   logic [CMW-1:0]        c_mag;
   logic [NW-1:0]         csq_ff;
   logic [LW-1:0]         rem_ff, div_trial;
   logic [QW-1:0]         quo_ff;
   logic                  div_ge;
   logic [SW-1:0]         srad_ff, sq_src;
   logic [SQW-1:0]        min_sq;
   logic [RW-1:0]         root_ff;
   logic [RW+2:0]         srem_ff, sq_trem, sq_trial;
   logic                  sq_ge;
   logic [XW-1:0]         root_x;
   logic [DIST_BITS-1:0]  dist_val, min_ff, min_in;
   logic                  rsp_valid_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff, rsp_min_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff  <= '0;
         sy_ff  <= '0;
         ex_ff  <= '0;
         ey_ff  <= '0;
         tol_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SEG_START_X: sx_ff  <= csr_data[CW-1:0];
            CSR_SEG_START_Y: sy_ff  <= csr_data[CW-1:0];
            CSR_SEG_END_X:   ex_ff  <= csr_data[CW-1:0];
            CSR_SEG_END_Y:   ey_ff  <= csr_data[CW-1:0];
            CSR_TOL:         tol_ff <= csr_data[TOL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // operand capture
   assign px_ext = DW'(signed'(req_point_x[CW-1:0]));
   assign py_ext = DW'(signed'(req_point_y[CW-1:0]));
   assign sx_ext = DW'(sx_ff);
   assign sy_ext = DW'(sy_ff);
   assign ex_ext = DW'(ex_ff);
   assign ey_ext = DW'(ey_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         first_ff <= req_first_of_set;
         dx_ff    <= ex_ext - sx_ext;
         dy_ff    <= ey_ext - sy_ext;
         p1x_ff   <= px_ext - sx_ext;
         p1y_ff   <= py_ext - sy_ext;
         p2x_ff   <= px_ext - ex_ext;
         p2y_ff   <= py_ext - ey_ext;
      end
   end

   // shared multiplier
   assign c_mag = c_ff[CBW-1] ? CMW'(-c_ff) : CMW'(c_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_P1X_P1X: begin mul_a = MW'(p1x_ff); mul_b = MW'(p1x_ff); end
         MUL_P1Y_P1Y: begin mul_a = MW'(p1y_ff); mul_b = MW'(p1y_ff); end
         MUL_P2X_P2X: begin mul_a = MW'(p2x_ff); mul_b = MW'(p2x_ff); end
         MUL_P2Y_P2Y: begin mul_a = MW'(p2y_ff); mul_b = MW'(p2y_ff); end
         MUL_DX_DX:   begin mul_a = MW'(dx_ff);  mul_b = MW'(dx_ff);  end
         MUL_DY_DY:   begin mul_a = MW'(dy_ff);  mul_b = MW'(dy_ff);  end
         MUL_P1X_DX:  begin mul_a = MW'(p1x_ff); mul_b = MW'(dx_ff);  end
         MUL_P1Y_DY:  begin mul_a = MW'(p1y_ff); mul_b = MW'(dy_ff);  end
         MUL_P1X_DY:  begin mul_a = MW'(p1x_ff); mul_b = MW'(dy_ff);  end
         MUL_P1Y_DX:  begin mul_a = MW'(p1y_ff); mul_b = MW'(dx_ff);  end
         MUL_CHI_CHI: begin
            mul_a = signed'({2'b00, c_mag[CMW-1:K]});
            mul_b = signed'({2'b00, c_mag[CMW-1:K]});
         end
         MUL_CHI_CLO: begin
            mul_a = signed'({2'b00, c_mag[CMW-1:K]});
            mul_b = signed'({1'b0, c_mag[K-1:0]});
         end
         MUL_CLO_CLO: begin
            mul_a = signed'({1'b0, c_mag[K-1:0]});
            mul_b = signed'({1'b0, c_mag[K-1:0]});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // accumulator and result stores
   assign prod_ext = AW'(prod_ff);

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:    acc_in = prod_ext;
         ACC_ADD:     acc_in = acc_ff + prod_ext;
         ACC_SUB:     acc_in = acc_ff - prod_ext;
         ACC_LOAD_HI: acc_in = prod_ext <<< (2 * K);
         ACC_ADD_MID: acc_in = acc_ff + (prod_ext <<< (K + 1));
         default:     acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (cmd.store)
         ST_P1SQ: p1sq_ff <= acc_in[SQW-1:0];
         ST_P2SQ: p2sq_ff <= acc_in[SQW-1:0];
         ST_LEN2: len2_ff <= acc_in[SQW-1:0];
         ST_DOT:  dot_ff  <= acc_in[SQW-1:0];
         ST_C:    c_ff    <= acc_in[CBW-1:0];
         ST_CSQ:  csq_ff  <= acc_in[NW-1:0];
         default: begin
         end
      endcase
   end

   // branch tests
   assign dx_mag = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
   assign dy_mag = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);

   assign status.collapsed = (dx_mag <= DW'(tol_ff)) && (dy_mag <= DW'(tol_ff));
   assign status.outside   = dot_ff[SQW-1] || (SQW'(dot_ff) > len2_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // restoring divider, one quotient bit per cycle
   assign div_trial = {rem_ff[LW-2:0], quo_ff[QW-1]};
   assign div_ge    = div_trial >= LW'(len2_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= LW'(csq_ff[NW-1:QW]);
         quo_ff <= csq_ff[QW-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? (div_trial - LW'(len2_ff)) : div_trial;
         quo_ff <= {quo_ff[QW-2:0], div_ge};
      end
   end

   // square root, one root bit per cycle
   assign min_sq = (p1sq_ff < p2sq_ff) ? p1sq_ff : p2sq_ff;

   always_comb begin
      case (cmd.sqrt_src)
         SRC_P1SQ: sq_src = p1sq_ff[SW-1:0];
         SRC_MIN:  sq_src = min_sq[SW-1:0];
         SRC_QUOT: sq_src = SW'(quo_ff);
         default:  sq_src = '0;
      endcase
   end

   assign sq_trem  = {srem_ff[RW:0], srad_ff[SW-1:SW-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_trem >= sq_trial;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         srad_ff <= sq_src;
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         srad_ff <= {srad_ff[SW-3:0], 2'b00};
         root_ff <= {root_ff[RW-2:0], sq_ge};
         srem_ff <= sq_ge ? (sq_trem - sq_trial) : sq_trem;
      end
   end

   // saturation, running minimum, response register
   assign root_x   = XW'(root_ff);
   assign dist_val = (root_x > XW'(DIST_MAX)) ? DIST_MAX : root_x[DIST_BITS-1:0];
   assign min_in   = (first_ff || (dist_val < min_ff)) ? dist_val : min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= DIST_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.result_load) begin
            min_ff       <= min_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_dist_ff <= dist_val;
         rsp_min_ff  <= min_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_distance = rsp_dist_ff;
   assign rsp_running_min    = rsp_min_ff;

endmodule

// ===== rtl/point_segment_min_distance_unit.sv =====
// ----------------------------------------------------------------------------
// point_segment_min_distance_unit
// distance from streamed points to a programmed segment, with running minimum
//
//   channel  dir  carries
//   req_ch   in   point_x, point_y, first_of_set
//   rsp_ch   out  point_distance, running_min
//   csr_ch   in   index, data (always ready)
//
// each request is accepted, runs the thirteen shared products, a decide step,
// the restoring divider when the projection lands on the segment, the square
// root and then the hand-off. a new request is taken while the last response
// waits; the next response waits for the slot. reset clears the segment and
// tolerance registers to 0 and the running minimum to all ones.
// ----------------------------------------------------------------------------
module point_segment_min_distance_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   psd_req_if.sink   req_ch,
   psd_rsp_if.source rsp_ch,
   psd_csr_if.sink   csr_ch
);
   import psd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   psd_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   psd_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_point_x        (req_ch.point_x),
      .req_point_y        (req_ch.point_y),
      .req_first_of_set   (req_ch.first_of_set),
      .csr_valid          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_point_distance (rsp_ch.point_distance),
      .rsp_running_min    (rsp_ch.running_min)
   );

endmodule

// ===== tb/sv/point_segment_min_distance_unit_test.sv =====
// ----------------------------------------------------------------------------
// point_segment_min_distance_unit_test
// streams points against a series of programmed segments, predicts distance
// and running minimum per request and checks every response in order
// ----------------------------------------------------------------------------
import psd_pkg::*;

class point_distance_scoreboard;
   typedef struct {
      logic [DIST_BITS-1:0] distance;
      logic [DIST_BITS-1:0] minimum;
   } answer_type;

   logic signed [15:0]   seg_sx, seg_sy, seg_ex, seg_ey;
   logic [TOL_BITS-1:0]  tol;
   logic [DIST_BITS-1:0] min_dist;
   answer_type           answers[$];
   int                   mismatches;

   function new();
      seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0; tol = 0;
      min_dist = DIST_MAX;
      mismatches = 0;
   endfunction

   function void write_reg(csr_idx_type idx, logic [15:0] data);
      case (idx)
         CSR_SEG_START_X: seg_sx = data;
         CSR_SEG_START_Y: seg_sy = data;
         CSR_SEG_END_X:   seg_ex = data;
         CSR_SEG_END_Y:   seg_ey = data;
         CSR_TOL:         tol = data[TOL_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [DIST_BITS-1:0] segment_distance(logic signed [15:0] px,
                                                            logic signed [15:0] py);
      longint dx, dy, p1x, p1y, p2x, p2y, p1sq, p2sq, len2, dot, c;
      logic [127:0] cm, quot;
      logic [63:0] dsq, r;
      dx = longint'(seg_ex) - longint'(seg_sx);
      dy = longint'(seg_ey) - longint'(seg_sy);
      p1x = longint'(px) - longint'(seg_sx);
      p1y = longint'(py) - longint'(seg_sy);
      p1sq = p1x * p1x + p1y * p1y;
      if (magnitude(dx) <= longint'(tol) && magnitude(dy) <= longint'(tol)) begin
         dsq = p1sq;
      end else begin
         len2 = dx * dx + dy * dy;
         dot = p1x * dx + p1y * dy;
         if (dot < 0 || dot > len2) begin
            p2x = longint'(px) - longint'(seg_ex);
            p2y = longint'(py) - longint'(seg_ey);
            p2sq = p2x * p2x + p2y * p2y;
            dsq = p1sq < p2sq ? p1sq : p2sq;
         end else begin
            c = p1x * dy - p1y * dx;
            cm = magnitude(c);
            quot = (cm * cm) / len2;
            dsq = quot[63:0];
         end
      end
      r = root_floor(dsq);
      return r > DIST_MAX ? DIST_MAX : r[DIST_BITS-1:0];
   endfunction

   function void note_point(logic signed [15:0] px, logic signed [15:0] py, logic first);
      answer_type a;
      a.distance = segment_distance(px, py);
      if (first || a.distance < min_dist) min_dist = a.distance;
      a.minimum = min_dist;
      answers.push_back(a);
   endfunction

   function void check_result(logic [DIST_BITS-1:0] distance, logic [DIST_BITS-1:0] minimum);
      answer_type a;
      if (answers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: distance %0d min %0d", distance, minimum);
         return;
      end
      a = answers.pop_front();
      if (distance !== a.distance || minimum !== a.minimum) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected distance %0d min %0d, got distance %0d min %0d",
                     a.distance, a.minimum, distance, minimum);
      end
   endfunction
endclass

module point_segment_min_distance_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 100;

   logic clock = 0;
   logic reset = 1;
   logic quiet = 0;
   int   rsp_stall = 0;

   psd_req_if #(.COORD_BITS(16)) req_ch ();
   psd_rsp_if                    rsp_ch ();
   psd_csr_if #(.COORD_BITS(16)) csr_ch ();

   point_distance_scoreboard board = new();

   point_segment_min_distance_unit #(.COORD_BITS(16)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 9);
      if (r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.point_distance, rsp_ch.running_min);
      if (rsp_stall > 0) begin
         rsp_ch.ready <= 0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1;
         if (!quiet && $urandom_range(0, 5) == 0) rsp_stall <= pick_gap();
      end
   end

   task automatic write_segment(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                                logic [15:0] ey, logic [15:0] tol_word);
      logic [15:0] vals[5];
      csr_idx_type idx[5];
      vals = '{sx, sy, ex, ey, tol_word};
      idx = '{CSR_SEG_START_X, CSR_SEG_START_Y, CSR_SEG_END_X, CSR_SEG_END_Y, CSR_TOL};
      for (int i = 0; i < 5; i++) begin
         csr_ch.valid <= 1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= vals[i];
         do @(posedge clock); while (!csr_ch.ready);
         board.write_reg(idx[i], vals[i]);
      end
      csr_ch.valid <= 0;
   endtask

   task automatic send_point(logic [15:0] px, logic [15:0] py, logic first);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1;
      req_ch.point_x      <= px;
      req_ch.point_y      <= py;
      req_ch.first_of_set <= first;
      do @(posedge clock); while (!req_ch.ready);
      board.note_point(px, py, first);
   endtask

   task automatic settle();
      req_ch.valid <= 0;
      while (board.answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_points(int count);
      int k, sx, sy, ex, ey, x, y;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            sx = $signed(board.seg_sx); sy = $signed(board.seg_sy);
            ex = $signed(board.seg_ex); ey = $signed(board.seg_ey);
            k = $urandom_range(0, 320) - 32;
            x = sx + (ex - sx) * k / 256 + $signed($urandom_range(0, 2047)) - 1024;
            y = sy + (ey - sy) * k / 256 + $signed($urandom_range(0, 2047)) - 1024;
            send_point(x[15:0], y[15:0], $urandom_range(0, 7) == 0);
         end else begin
            send_point(16'($urandom()), 16'($urandom()), $urandom_range(0, 7) == 0);
         end
      end
   endtask

   initial begin
      req_ch.valid = 0; req_ch.point_x = 0; req_ch.point_y = 0; req_ch.first_of_set = 0;
      csr_ch.valid = 0; csr_ch.index = CSR_SEG_START_X; csr_ch.data = 0;
      rsp_ch.ready = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // no set started yet, default zero segment
      send_point(16'sd300, -16'sd400, 0);
      send_point(16'sd0, 16'sd0, 0);
      settle();

      write_segment(-16'sd1000, 16'sd0, 16'sd1000, 16'sd0, 16'd0);
      send_point(16'sd0, 16'sd512, 1);
      send_point(-16'sd2000, 16'sd300, 0);
      send_point(16'sd1500, -16'sd200, 0);
      send_point(16'sd1000, 16'sd0, 0);
      send_point(-16'sd1000, 16'sd0, 0);
      send_point(16'sd7, -16'sd1, 0);
      send_point(16'h7FFF, 16'h7FFF, 1);
      send_point(16'h8000, 16'h8000, 0);
      send_point(16'h7FFF, 16'h8000, 0);
      send_point(16'h8000, 16'h7FFF, 0);
      settle();

      write_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFF00);
      send_point(16'h7FFF, 16'h7FFF, 1);
      send_point(16'h8000, 16'h8000, 0);
      settle();

      write_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd255);
      send_point(16'h7FFF, 16'h8000, 1);
      send_point(16'h8000, 16'h7FFF, 0);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h8000, 16'h8000, 0);
      settle();

      write_segment(16'sd100, -16'sd50, 16'sd130, -16'sd40, 16'd255);
      send_point(16'sd120, -16'sd45, 1);
      send_point(16'sd5000, 16'sd5000, 0);
      settle();

      write_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd0);
      random_points(50);
      settle();

      for (int p = 0; p < 9; p++) begin
         quiet = (p % 3 == 1);
         case (p % 3)
            0: write_segment(16'($urandom()), 16'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()));
            1: write_segment(16'($urandom_range(0, 4000) - 2000),
                             16'($urandom_range(0, 4000) - 2000),
                             16'($urandom_range(0, 4000) - 2000),
                             16'($urandom_range(0, 4000) - 2000),
                             16'($urandom_range(0, 255)));
            default: write_segment(16'($urandom_range(0, 60000) - 30000),
                                   16'($urandom_range(0, 60000) - 30000),
                                   16'($urandom_range(0, 60000) - 30000),
                                   16'($urandom_range(0, 60000) - 30000),
                                   16'($urandom_range(0, 15)));
         endcase
         random_points(50);
         settle();
      end

      if (board.mismatches == 0 && board.answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
